/* rtl/core/fga_pkg.sv */
// shared types and constants for the fuzzy grade alu
`default_nettype none
package fga_pkg;

    localparam int FRAC_BITS = 8;
    localparam int GRADE_W   = 15;
    localparam int CMD_W     = 5;
    localparam int CNT_W     = 2;
    localparam int STAT_W    = 3;
    localparam int PROD_W    = 2 * GRADE_W;
    // one restoring step per quotient bit
    localparam int QUOT_STEPS = GRADE_W;

    localparam logic [GRADE_W-1:0] FULL_SCALE = GRADE_W'(100 << FRAC_BITS);

    typedef enum logic [CMD_W-1:0] {
        CMD_GT      = 5'd0,
        CMD_EQ      = 5'd1,
        CMD_NE      = 5'd2,
        CMD_LT      = 5'd3,
        CMD_GE      = 5'd4,
        CMD_LE      = 5'd5,
        CMD_ADD     = 5'd6,
        CMD_SUB     = 5'd7,
        CMD_MUL     = 5'd8,
        CMD_DIV     = 5'd9,
        CMD_MIN     = 5'd10,
        CMD_MAX     = 5'd11,
        CMD_ABSDIF  = 5'd12,
        CMD_NOT     = 5'd13,
        CMD_NOTMIN  = 5'd14,
        CMD_NOR     = 5'd15,
        CMD_SELECT  = 5'd16,
        CMD_GATE    = 5'd17,
        CMD_PASS    = 5'd18,
        CMD_NONZERO = 5'd19,
        CMD_BOTHNZ  = 5'd20
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_DIV0    = 3'd1,
        STAT_SAT     = 3'd2,
        STAT_FEW     = 3'd3,
        STAT_UNKNOWN = 3'd4
    } t_status;

    // item as it moves down the chain of division cells
    typedef struct packed {
        logic [GRADE_W-1:0] rem;       // partial remainder
        logic [GRADE_W-1:0] nlow;      // numerator bits still to shift, quotient shifts in
        logic [GRADE_W-1:0] divisor;
        logic               use_quot;  // result is the quotient
        logic [GRADE_W-1:0] grade;     // result when not from the quotient
        t_status            status;
    } t_stage;

endpackage
`default_nettype wire

/* rtl/core/fga_front.sv */
// operand decode, direct results and the single multiply ahead of the cell chain
`default_nettype none
module fga_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    output logic                               o_rdy,
    input  wire logic [fga_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [fga_pkg::CNT_W-1:0]     i_cnt,
    input  wire logic [fga_pkg::GRADE_W-1:0]   i_a,
    input  wire logic [fga_pkg::GRADE_W-1:0]   i_b,
    input  wire logic [fga_pkg::GRADE_W-1:0]   i_c,
    output logic                               o_vld,
    input  wire logic                          i_rdy,
    output fga_pkg::t_stage                    o_stage
);

    logic                          r_vld;
    fga_pkg::t_stage               r_stage;
    fga_pkg::t_stage               n_stage;

    logic [fga_pkg::GRADE_W-1:0]   a_s;
    logic [fga_pkg::GRADE_W-1:0]   b_s;
    logic [fga_pkg::GRADE_W-1:0]   c_s;
    logic [fga_pkg::GRADE_W-1:0]   lo;
    logic [fga_pkg::GRADE_W-1:0]   hi;
    logic [fga_pkg::GRADE_W:0]     sum;
    logic [fga_pkg::GRADE_W-1:0]   mul_b;
    logic [fga_pkg::PROD_W-1:0]    prod;
    logic [fga_pkg::CNT_W-1:0]     need;
    logic                          is_div;
    fga_pkg::t_cmd                 cmd;

    assign cmd    = fga_pkg::t_cmd'(i_cmd);
    assign a_s    = (i_a > fga_pkg::FULL_SCALE) ? fga_pkg::FULL_SCALE : i_a;
    assign b_s    = (i_b > fga_pkg::FULL_SCALE) ? fga_pkg::FULL_SCALE : i_b;
    assign c_s    = (i_c > fga_pkg::FULL_SCALE) ? fga_pkg::FULL_SCALE : i_c;
    assign lo     = (a_s < b_s) ? a_s : b_s;
    assign hi     = (a_s < b_s) ? b_s : a_s;
    assign sum    = {1'b0, a_s} + {1'b0, b_s};
    assign is_div = (cmd == fga_pkg::CMD_DIV);

    // multiply gives a*b for the product or a*full for the quotient
    assign mul_b = is_div ? fga_pkg::FULL_SCALE : b_s;
    assign prod  = {{fga_pkg::GRADE_W{1'b0}}, a_s} * {{fga_pkg::GRADE_W{1'b0}}, mul_b};

    always_comb begin
        case (cmd)
            fga_pkg::CMD_NOT, fga_pkg::CMD_PASS, fga_pkg::CMD_NONZERO: need = 2'd1;
            fga_pkg::CMD_SELECT: need = 2'd3;
            default: need = 2'd2;
        endcase
    end

    always_comb begin
        n_stage.rem      = prod[fga_pkg::PROD_W-1:fga_pkg::GRADE_W];
        n_stage.nlow     = prod[fga_pkg::GRADE_W-1:0];
        n_stage.divisor  = is_div ? b_s : fga_pkg::FULL_SCALE;
        n_stage.use_quot = 1'b0;
        n_stage.grade    = '0;
        n_stage.status   = fga_pkg::STAT_OK;
        if (i_cmd > fga_pkg::CMD_BOTHNZ) begin
            n_stage.status = fga_pkg::STAT_UNKNOWN;
        end else if (i_cnt < need) begin
            n_stage.status = fga_pkg::STAT_FEW;
        end else begin
            case (cmd)
                fga_pkg::CMD_GT: n_stage.grade = (a_s > b_s) ? fga_pkg::FULL_SCALE : '0;
                fga_pkg::CMD_EQ: n_stage.grade = (a_s == b_s) ? fga_pkg::FULL_SCALE : '0;
                fga_pkg::CMD_NE: n_stage.grade = (a_s != b_s) ? fga_pkg::FULL_SCALE : '0;
                fga_pkg::CMD_LT: n_stage.grade = (a_s < b_s) ? fga_pkg::FULL_SCALE : '0;
                fga_pkg::CMD_GE: n_stage.grade = (a_s >= b_s) ? fga_pkg::FULL_SCALE : '0;
                fga_pkg::CMD_LE: n_stage.grade = (a_s <= b_s) ? fga_pkg::FULL_SCALE : '0;
                fga_pkg::CMD_ADD: begin
                    n_stage.grade = (sum > {1'b0, fga_pkg::FULL_SCALE}) ?
                                    fga_pkg::FULL_SCALE : sum[fga_pkg::GRADE_W-1:0];
                end
                fga_pkg::CMD_SUB: n_stage.grade = (a_s > b_s) ? a_s - b_s : '0;
                fga_pkg::CMD_MUL: n_stage.use_quot = 1'b1;
                fga_pkg::CMD_DIV: begin
                    // a above b always gives a quotient above full scale
                    if (b_s == '0) begin
                        n_stage.status = fga_pkg::STAT_DIV0;
                    end else if (a_s > b_s) begin
                        n_stage.grade  = fga_pkg::FULL_SCALE;
                        n_stage.status = fga_pkg::STAT_SAT;
                    end else begin
                        n_stage.use_quot = 1'b1;
                    end
                end
                fga_pkg::CMD_MIN:    n_stage.grade = lo;
                fga_pkg::CMD_MAX:    n_stage.grade = hi;
                fga_pkg::CMD_ABSDIF: n_stage.grade = hi - lo;
                fga_pkg::CMD_NOT:    n_stage.grade = fga_pkg::FULL_SCALE - a_s;
                fga_pkg::CMD_NOTMIN: n_stage.grade = fga_pkg::FULL_SCALE - lo;
                fga_pkg::CMD_NOR:    n_stage.grade = fga_pkg::FULL_SCALE - hi;
                fga_pkg::CMD_SELECT: n_stage.grade = (a_s != '0) ? b_s : c_s;
                fga_pkg::CMD_GATE:   n_stage.grade = (a_s != '0) ? b_s : '0;
                fga_pkg::CMD_PASS:   n_stage.grade = a_s;
                fga_pkg::CMD_NONZERO: begin
                    n_stage.grade = (a_s != '0) ? fga_pkg::FULL_SCALE : '0;
                end
                default: begin
                    n_stage.grade = (a_s != '0 && b_s != '0) ? fga_pkg::FULL_SCALE : '0;
                end
            endcase
        end
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

/* rtl/core/fga_cell.sv */
// one restoring division step with its own item register
`default_nettype none
module fga_cell (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_vld,
    output logic            o_rdy,
    input  wire fga_pkg::t_stage i_stage,
    output logic            o_vld,
    input  wire logic       i_rdy,
    output fga_pkg::t_stage o_stage
);

    logic                        r_vld;
    fga_pkg::t_stage             r_stage;
    fga_pkg::t_stage             n_stage;
    logic [fga_pkg::GRADE_W:0]   trial;
    logic [fga_pkg::GRADE_W:0]   diff;
    logic                        q_bit;

    // bring down the next numerator bit and try the divisor
    assign trial = {i_stage.rem, i_stage.nlow[fga_pkg::GRADE_W-1]};
    assign diff  = trial - {1'b0, i_stage.divisor};
    assign q_bit = (trial >= {1'b0, i_stage.divisor});

    always_comb begin
        n_stage      = i_stage;
        n_stage.rem  = q_bit ? diff[fga_pkg::GRADE_W-1:0] : trial[fga_pkg::GRADE_W-1:0];
        n_stage.nlow = {i_stage.nlow[fga_pkg::GRADE_W-2:0], q_bit};
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

/* rtl/core/fuzzy_grade_alu_core.sv */
// top level of the fuzzy grade alu: decode stage followed by a chain of division cells
//
// channel   dir   handshake                    payload
// s         in    i_s_tvalid / o_s_tready      i_s_tdata: cmd, count, a, b, c
// m         out   o_m_tvalid / i_m_tready      o_m_tdata: grade, status
//
// one item enters per cycle while the output is not stalled; every item passes the decode
// stage and fifteen division cells whatever the command
// the chain of one-bit restoring cells sets the latency, one quotient bit per cell
// synchronous active-low reset empties every stage
// each stage holds its item only while the one after it is full and stalled,
// so bubbles close up and input is taken while a result waits at the output
`default_nettype none
module fuzzy_grade_alu_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,   // command[4:0], operand_count[6:5], operand_a[21:7],
                                          // operand_b[36:22], operand_c[51:37], zero pad
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // grade_out[14:0], status[17:15], zero pad
);

    logic            w_vld [0:fga_pkg::QUOT_STEPS];
    logic            w_rdy [0:fga_pkg::QUOT_STEPS];
    fga_pkg::t_stage w_stage [0:fga_pkg::QUOT_STEPS];
    fga_pkg::t_stage last;

    fga_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_cmd   (i_s_tdata[4:0]),
        .i_cnt   (i_s_tdata[6:5]),
        .i_a     (i_s_tdata[21:7]),
        .i_b     (i_s_tdata[36:22]),
        .i_c     (i_s_tdata[51:37]),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_stage (w_stage[0])
    );

    for (genvar k = 0; k < fga_pkg::QUOT_STEPS; k++) begin : g_cell
        fga_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[k]),
            .o_rdy   (w_rdy[k]),
            .i_stage (w_stage[k]),
            .o_vld   (w_vld[k+1]),
            .i_rdy   (w_rdy[k+1]),
            .o_stage (w_stage[k+1])
        );
    end

    assign last = w_stage[fga_pkg::QUOT_STEPS];
    assign w_rdy[fga_pkg::QUOT_STEPS] = i_m_tready;
    assign o_m_tvalid = w_vld[fga_pkg::QUOT_STEPS];
    // after the last cell the shifted numerator field holds the quotient
    assign o_m_tdata  = {6'd0, last.status, last.use_quot ? last.nlow : last.grade};

    a_grade_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[14:0] <= fga_pkg::FULL_SCALE)
        else $error("result grade above full scale");

    a_sat_is_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[17:15] == fga_pkg::STAT_SAT)
            |-> o_m_tdata[14:0] == fga_pkg::FULL_SCALE)
        else $error("saturated quotient not at full scale");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[17:15] == fga_pkg::STAT_DIV0 ||
                        o_m_tdata[17:15] == fga_pkg::STAT_FEW ||
                        o_m_tdata[17:15] == fga_pkg::STAT_UNKNOWN))
            |-> o_m_tdata[14:0] == '0)
        else $error("error status with nonzero grade");

    a_stall_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled while output side is free");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid straight after reset");

endmodule
`default_nettype wire
